// ----- design/cfb_pkg.sv -----
// Shared types, constants and the checksum fold for the frame builder.
`default_nettype none

package cfb_pkg;

   // Largest payload length a start item may announce
   localparam int unsigned MaxPayload = 34;

   // Most result bytes one item can cause (header plus trailer)
   localparam int unsigned BurstDepth = 6;
   localparam int unsigned CountWidth = $clog2(BurstDepth + 1);
   localparam int unsigned IdxWidth   = $clog2(BurstDepth);

   // Frame bytes and mixing constants
   localparam logic [7:0] HeadByte = 8'hF0;
   localparam logic [7:0] TailByte = 8'hFF;
   localparam logic [7:0] MixHi    = 8'h5A;
   localparam logic [7:0] MixLo    = 8'hA5;

   // Item modes
   localparam logic ModeStart   = 1'b0;
   localparam logic ModePayload = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] command;
      logic [5:0] payload_length;
      logic [7:0] payload_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
      logic       error;
   } rsp_entry_type;

   typedef rsp_entry_type [BurstDepth-1:0] rsp_burst_type;

   // Checksum term of one byte: (((t ^ 5A) << 8) + t) ^ A5, 16 bits
   function automatic logic [15:0] fold_term(input logic [7:0] t);
      logic [15:0] shifted;
      logic [15:0] summed;
      begin
         shifted = {t ^ MixHi, 8'h00};
         summed  = shifted + {8'h00, t};
         return summed ^ {8'h00, MixLo};
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/cfb_in_stage.sv -----
// Input register of the frame builder: holds one item until the builder takes it.
`default_nettype none

module cfb_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire cfb_pkg::req_item_type req_item,
   input  wire logic                  take,
   output logic                       item_valid,
   output cfb_pkg::req_item_type      item
);
   import cfb_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   // Stall while a held item is not taken this cycle
   assign req_stall = valid_ff & ~take;
   assign accept    = req_valid & ~req_stall;

   // Hold valid until the builder takes the item
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- design/cfb_builder.sv -----
// Frame state and result list: turns one item into its burst of frame bytes.
`default_nettype none

module cfb_builder (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire cfb_pkg::req_item_type item,
   output cfb_pkg::rsp_burst_type     burst,
   output logic [cfb_pkg::CountWidth-1:0] burst_count
);
   import cfb_pkg::*;

   logic [15:0] running_sum_ff;
   logic [15:0] running_sum_in;
   logic [5:0]  bytes_left_ff;
   logic [5:0]  bytes_left_in;
   logic        frame_open_ff;
   logic        frame_open_in;

   logic [15:0] start_sum;
   logic [15:0] payload_sum;
   rsp_entry_type err_entry;

   // Checksum of the header and of a payload byte added to the open sum
   assign start_sum   = fold_term(HeadByte) + fold_term(item.command)
                        + fold_term({2'b00, item.payload_length});
   assign payload_sum = running_sum_ff + fold_term(item.payload_byte);

   assign err_entry = '{frame_byte: 8'h00, end_of_frame: 1'b0, error: 1'b1};

   // Build the result list and the next frame state
   always_comb begin
      burst          = '0;
      burst_count    = '0;
      running_sum_in = running_sum_ff;
      bytes_left_in  = bytes_left_ff;
      frame_open_in  = frame_open_ff;
      if (item.mode == ModeStart) begin
         if ({26'd0, item.payload_length} > MaxPayload) begin
            // Abandon any open frame and flag the length
            burst[0]       = err_entry;
            burst_count    = CountWidth'(1);
            running_sum_in = '0;
            bytes_left_in  = '0;
            frame_open_in  = 1'b0;
         end else begin
            burst[0] = '{frame_byte: HeadByte, end_of_frame: 1'b0, error: 1'b0};
            burst[1] = '{frame_byte: item.command, end_of_frame: 1'b0, error: 1'b0};
            burst[2] = '{frame_byte: {2'b00, item.payload_length},
                         end_of_frame: 1'b0, error: 1'b0};
            running_sum_in = start_sum;
            if (item.payload_length == 6'd0) begin
               // Empty payload: close the frame right after the header
               burst[3] = '{frame_byte: start_sum[15:8], end_of_frame: 1'b0, error: 1'b0};
               burst[4] = '{frame_byte: start_sum[7:0], end_of_frame: 1'b0, error: 1'b0};
               burst[5] = '{frame_byte: TailByte, end_of_frame: 1'b1, error: 1'b0};
               burst_count   = CountWidth'(6);
               bytes_left_in = '0;
               frame_open_in = 1'b0;
            end else begin
               burst_count   = CountWidth'(3);
               bytes_left_in = item.payload_length;
               frame_open_in = 1'b1;
            end
         end
      end else if (!frame_open_ff) begin
         // Payload with no frame open: flag it, keep the state
         burst[0]    = err_entry;
         burst_count = CountWidth'(1);
      end else begin
         burst[0] = '{frame_byte: item.payload_byte, end_of_frame: 1'b0, error: 1'b0};
         running_sum_in = payload_sum;
         if (bytes_left_ff == 6'd1) begin
            // Last payload byte: append the trailer
            burst[1] = '{frame_byte: payload_sum[15:8], end_of_frame: 1'b0, error: 1'b0};
            burst[2] = '{frame_byte: payload_sum[7:0], end_of_frame: 1'b0, error: 1'b0};
            burst[3] = '{frame_byte: TailByte, end_of_frame: 1'b1, error: 1'b0};
            burst_count   = CountWidth'(4);
            bytes_left_in = '0;
            frame_open_in = 1'b0;
         end else begin
            burst_count   = CountWidth'(1);
            bytes_left_in = bytes_left_ff - 6'd1;
         end
      end
   end

   // Advance the frame state when the burst is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
         bytes_left_ff  <= '0;
         frame_open_ff  <= 1'b0;
      end else if (load) begin
         running_sum_ff <= running_sum_in;
         bytes_left_ff  <= bytes_left_in;
         frame_open_ff  <= frame_open_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/cfb_out_buffer.sv -----
// Result register bank: holds one burst of frame bytes and hands them out in order.
`default_nettype none

module cfb_out_buffer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire cfb_pkg::rsp_burst_type        burst,
   input  wire logic [cfb_pkg::CountWidth-1:0] burst_count,
   output logic                               free,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output cfb_pkg::rsp_entry_type             rsp_entry
);
   import cfb_pkg::*;

   rsp_burst_type         entries_ff;
   logic [CountWidth-1:0] count_ff;
   logic [IdxWidth-1:0]   idx_ff;
   logic                  pop;
   logic                  last;

   assign rsp_valid = (count_ff != '0);
   assign rsp_entry = entries_ff[idx_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   assign last      = (idx_ff == IdxWidth'(count_ff - CountWidth'(1)));

   // Take a new burst when empty or when the last byte leaves now
   assign free = ~rsp_valid | (pop & last);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (load) begin
         count_ff <= burst_count;
         idx_ff   <= '0;
      end else if (pop) begin
         if (last) begin
            count_ff <= '0;
            idx_ff   <= '0;
         end else begin
            idx_ff <= idx_ff + IdxWidth'(1);
         end
      end
   end

   // Capture the burst payload
   always_ff @(posedge clock) begin
      if (load) begin
         entries_ff <= burst;
      end
   end

endmodule

`default_nettype wire

// ----- design/checksum_frame_builder.sv -----
// Top level of the checksum frame builder: input register, builder and result buffer.
`default_nettype none

// Builds checksummed frames one byte per result. A start item (mode 0) gives
// the header F0, command, length; payload items (mode 1) pass their byte
// through; the frame closes with sum high, sum low and FF (end_of_frame).
// A too-long length or a payload byte with no open frame gives one error
// result. An item is taken each cycle as long as each gives one result and
// the output does not stall; an item that gives n results (n up to 6) occupies
// the single result buffer until it drains its last byte, and the input holds
// off until then. The first result of an item is offered once the item has
// passed through the input register and been loaded into the result buffer.
module checksum_frame_builder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_mode,
   input  wire logic [7:0] req_command,
   input  wire logic [5:0] req_payload_length,
   input  wire logic [7:0] req_payload_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_frame_byte,
   output logic            rsp_end_of_frame,
   output logic            rsp_error
);
   import cfb_pkg::*;

   req_item_type          req_item;
   req_item_type          item;
   logic                  item_valid;
   logic                  buf_free;
   logic                  load;
   rsp_burst_type         burst;
   logic [CountWidth-1:0] burst_count;
   rsp_entry_type         rsp_entry;

   assign req_item = '{mode: req_mode, command: req_command,
                       payload_length: req_payload_length,
                       payload_byte: req_payload_byte};

   // Move the held item into the buffer when it has room
   assign load = item_valid & buf_free;

   cfb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (load),
      .item_valid (item_valid),
      .item       (item)
   );

   cfb_builder u_builder (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .item        (item),
      .burst       (burst),
      .burst_count (burst_count)
   );

   cfb_out_buffer u_out_buffer (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .burst       (burst),
      .burst_count (burst_count),
      .free        (buf_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_entry   (rsp_entry)
   );

   assign rsp_frame_byte   = rsp_entry.frame_byte;
   assign rsp_end_of_frame = rsp_entry.end_of_frame;
   assign rsp_error        = rsp_entry.error;

endmodule

`default_nettype wire

// ----- design/cfb_checker.sv -----
// Port-level checks of the frame builder and their binding to the top level.
`default_nettype none

module cfb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_frame_byte,
   input wire logic       rsp_end_of_frame,
   input wire logic       rsp_error
);

   // Closing byte is always FF and never an error
   a_eof_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_frame_byte == 8'hFF && !rsp_error)
      else $error("end_of_frame on a byte other than FF");

   // Error items carry a zero byte and no end mark
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_frame_byte == 8'h00 && !rsp_end_of_frame)
      else $error("error item with nonzero byte or end mark");

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_end_of_frame) && $stable(rsp_error))
      else $error("stalled result changed");

endmodule

bind checksum_frame_builder cfb_checker u_cfb_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_byte   (rsp_frame_byte),
   .rsp_end_of_frame (rsp_end_of_frame),
   .rsp_error        (rsp_error)
);

`default_nettype wire
